// ===== hdl/hrhp_pkg.sv =====
// Package for the HTTP request head parser.
// Holds the word types of both channels, the parse phases and the status codes.
// Depends on nothing; every module of the parser uses it.
`default_nettype none
package hrhp_pkg;

  typedef struct packed {
    logic [7:0] request_byte;
    logic       first_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] head_length;
    logic        newline_appended;
  } out_word_t;

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_URL,
    PH_VERSION,
    PH_LINE,
    PH_LINE_CR,
    PH_COLON,
    PH_LF,
    PH_DONE
  } phase_t;

  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_OK      = 3'd1;
  localparam logic [2:0] ST_METHOD  = 3'd2;
  localparam logic [2:0] ST_VERSION = 3'd3;
  localparam logic [2:0] ST_LONG    = 3'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [3:0] METHOD_LAST  = 4'd3;
  localparam logic [3:0] VERSION_LAST = 4'd9;
  localparam logic [15:0] COUNT_LIMIT = 16'hFFFF;

  function automatic logic [7:0] method_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h47;
      4'd1:    ch = 8'h45;
      4'd2:    ch = 8'h54;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] version_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h48;
      4'd1:    ch = 8'h54;
      4'd2:    ch = 8'h54;
      4'd3:    ch = 8'h50;
      4'd4:    ch = 8'h2F;
      4'd5:    ch = 8'h31;
      4'd6:    ch = 8'h2E;
      4'd7:    ch = 8'h30;
      4'd8:    ch = 8'h0D;
      4'd9:    ch = 8'h0A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/hrhp_in_reg.sv =====
// Input register of the HTTP request head parser.
// Holds one incoming word until the parse stage takes it; uses hrhp_pkg.
`default_nettype none
module hrhp_in_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire hrhp_pkg::in_word_t in_data,
  input  wire logic             take,
  output logic                  held_valid,
  output hrhp_pkg::in_word_t    held_data
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_data <= in_data;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/hrhp_parser.sv =====
// Parse stage of the HTTP request head parser: parse state, one step per word,
// and the result register. Uses hrhp_pkg.
`default_nettype none
module hrhp_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [15:0]        max_length,
  input  wire logic               item_valid,
  input  wire hrhp_pkg::in_word_t item_data,
  output logic                    take,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output hrhp_pkg::out_word_t     out_data
);

  hrhp_pkg::phase_t phase, phase_next, phase_cur;
  logic [3:0]  match_index, match_index_next, match_cur;
  logic [15:0] bytes_seen, bytes_seen_next, seen_cur;
  logic [15:0] last_line_end, last_line_end_next, lle_cur;
  logic [2:0]  verdict, verdict_next, verdict_cur;
  logic [15:0] kept_length, kept_length_next, kept_cur;
  logic        kept_cut, kept_cut_next, cut_cur;
  logic [15:0] count;
  logic [7:0]  b;
  hrhp_pkg::out_word_t result;

  assign take = item_valid && (!out_valid || out_ready);
  assign b = item_data.request_byte;
  assign count = seen_cur + 16'd1;

  always_comb begin
    phase_cur   = phase;
    match_cur   = match_index;
    seen_cur    = bytes_seen;
    lle_cur     = last_line_end;
    verdict_cur = verdict;
    kept_cur    = kept_length;
    cut_cur     = kept_cut;
    if (item_data.first_byte) begin
      phase_cur   = hrhp_pkg::PH_METHOD;
      match_cur   = 4'd0;
      seen_cur    = 16'd0;
      lle_cur     = 16'd0;
      verdict_cur = hrhp_pkg::ST_BUSY;
      kept_cur    = 16'd0;
      cut_cur     = 1'b0;
    end
  end

  always_comb begin
    phase_next         = phase_cur;
    match_index_next   = match_cur;
    bytes_seen_next    = seen_cur;
    last_line_end_next = lle_cur;
    verdict_next       = verdict_cur;
    kept_length_next   = kept_cur;
    kept_cut_next      = cut_cur;
    if (phase_cur != hrhp_pkg::PH_DONE) begin
      bytes_seen_next = count;
      unique case (phase_cur)
        hrhp_pkg::PH_METHOD: begin
          if (match_cur < hrhp_pkg::METHOD_LAST) begin
            if (b != hrhp_pkg::method_char(match_cur)) begin
              phase_next       = hrhp_pkg::PH_DONE;
              verdict_next     = hrhp_pkg::ST_METHOD;
              kept_length_next = 16'd0;
              kept_cut_next    = 1'b0;
            end else begin
              match_index_next = match_cur + 4'd1;
            end
          end else begin
            phase_next       = hrhp_pkg::PH_URL;
            match_index_next = 4'd0;
          end
        end
        hrhp_pkg::PH_URL: begin
          if (b == hrhp_pkg::CH_SPACE) begin
            phase_next       = hrhp_pkg::PH_VERSION;
            match_index_next = 4'd0;
          end
        end
        hrhp_pkg::PH_VERSION: begin
          if (match_cur > hrhp_pkg::VERSION_LAST ||
              b != hrhp_pkg::version_char(match_cur)) begin
            phase_next       = hrhp_pkg::PH_DONE;
            verdict_next     = hrhp_pkg::ST_VERSION;
            kept_length_next = 16'd0;
            kept_cut_next    = 1'b0;
          end else if (match_cur == hrhp_pkg::VERSION_LAST) begin
            phase_next         = hrhp_pkg::PH_LINE;
            match_index_next   = 4'd0;
            last_line_end_next = count;
          end else begin
            match_index_next = match_cur + 4'd1;
          end
        end
        hrhp_pkg::PH_LINE: begin
          last_line_end_next = seen_cur;
          if (b == hrhp_pkg::CH_CR) begin
            phase_next = hrhp_pkg::PH_LINE_CR;
          end else if (b == hrhp_pkg::CH_COLON) begin
            phase_next = hrhp_pkg::PH_LF;
          end else begin
            phase_next = hrhp_pkg::PH_COLON;
          end
        end
        hrhp_pkg::PH_LINE_CR: begin
          if (b == hrhp_pkg::CH_LF) begin
            phase_next       = hrhp_pkg::PH_DONE;
            verdict_next     = hrhp_pkg::ST_OK;
            kept_length_next = count;
            kept_cut_next    = 1'b0;
          end else if (b == hrhp_pkg::CH_COLON) begin
            phase_next = hrhp_pkg::PH_LF;
          end else begin
            phase_next = hrhp_pkg::PH_COLON;
          end
        end
        hrhp_pkg::PH_COLON: begin
          if (b == hrhp_pkg::CH_COLON) begin
            phase_next = hrhp_pkg::PH_LF;
          end
        end
        hrhp_pkg::PH_LF: begin
          if (b == hrhp_pkg::CH_LF) begin
            phase_next = hrhp_pkg::PH_LINE;
          end
        end
        default: begin
          phase_next = hrhp_pkg::PH_DONE;
        end
      endcase

      if (phase_next != hrhp_pkg::PH_DONE &&
          (count == max_length || count == hrhp_pkg::COUNT_LIMIT)) begin
        if (phase_next <= hrhp_pkg::PH_VERSION) begin
          verdict_next     = hrhp_pkg::ST_LONG;
          kept_length_next = 16'd0;
          kept_cut_next    = 1'b0;
        end else begin
          verdict_next  = hrhp_pkg::ST_OK;
          kept_cut_next = 1'b1;
          if (last_line_end_next >= count) begin
            kept_length_next = last_line_end_next;
          end else begin
            kept_length_next = last_line_end_next + 16'd1;
          end
        end
        phase_next = hrhp_pkg::PH_DONE;
      end
    end
  end

  always_comb begin
    result.status           = hrhp_pkg::ST_BUSY;
    result.head_length      = 16'd0;
    result.newline_appended = 1'b0;
    if (phase_next == hrhp_pkg::PH_DONE) begin
      result.status           = verdict_next;
      result.head_length      = kept_length_next;
      result.newline_appended = kept_cut_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= hrhp_pkg::PH_METHOD;
      match_index   <= 4'd0;
      bytes_seen    <= 16'd0;
      last_line_end <= 16'd0;
      verdict       <= hrhp_pkg::ST_BUSY;
      kept_length   <= 16'd0;
      kept_cut      <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      match_index   <= match_index_next;
      bytes_seen    <= bytes_seen_next;
      last_line_end <= last_line_end_next;
      verdict       <= verdict_next;
      kept_length   <= kept_length_next;
      kept_cut      <= kept_cut_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/http_request_head_parser.sv =====
// HTTP request head parser, one request byte per word on the input channel and
// one status word out for every word taken in.
//
// The in channel carries request_byte and first_byte; first_byte restarts the
// parse at that byte. The out channel returns status, head_length and
// newline_appended for each input word, in order. The cfg channel writes
// max_length and is always ready; write it only while no word is in flight.
//
// From input acceptance to output valid, the accepting edge writes the input
// register and a later edge, when the parser takes the word, writes the parse
// result into the result register. Throughput is one word per cycle while the
// receiver takes results, set by the combinational parse step that updates the
// phase, match index, byte count and last line position.
// A stalled receiver holds the result register; the input register still takes
// one more word, after which in_ready drops until the result is taken.
// Reset clears both registers' valid flags, restarts the parse and sets
// max_length to 8192. Depends on hrhp_pkg, hrhp_in_reg and hrhp_parser.
`default_nettype none
module http_request_head_parser #(
  parameter logic [15:0] MAX_LENGTH_RESET = 16'd8192
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire hrhp_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output hrhp_pkg::out_word_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [15:0]         cfg_data
);

  logic [15:0]        max_length;
  logic               held_valid;
  hrhp_pkg::in_word_t held_data;
  logic               take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_length <= cfg_data;
    end
  end

  hrhp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (take),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  hrhp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .max_length (max_length),
    .item_valid (held_valid),
    .item_data  (held_data),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// ===== tb/http_request_head_parser_tb.sv =====
// Testbench for http_request_head_parser: streams GET request heads one byte per word and
// checks every status word against a cycle-free prediction of the parse, over several
// max_length settings and handshake pacing modes. Depends on hrhp_pkg and the parser RTL.
`timescale 1ns / 1ps
module http_request_head_parser_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam logic [23:0] GET_TEXT = "GET";
  localparam logic [79:0] VERSION_TEXT = {"HTTP/1.0", hrhp_pkg::CH_CR, hrhp_pkg::CH_LF};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  hrhp_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hrhp_pkg::out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  http_request_head_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  hrhp_pkg::in_word_t request_words[$];
  hrhp_pkg::out_word_t predicted_results[$];
  logic [7:0] request_bytes[$];
  hrhp_pkg::out_word_t want;
  int idle_mode = 0;
  int words_queued = 0;
  int words_accepted = 0;
  int results_checked = 0;
  int requests_queued = 0;
  int settings_used = 1;
  int error_count = 0;
  int quiet_cycles = 0;

  hrhp_pkg::phase_t step_phase;
  logic [3:0] match_pos;
  logic [15:0] byte_count;
  logic [15:0] line_start;
  logic [2:0] final_status;
  logic [15:0] final_length;
  logic final_cut;
  logic [15:0] max_length_cfg;

  function automatic void restart_head();
    step_phase = hrhp_pkg::PH_METHOD;
    match_pos = '0;
    byte_count = '0;
    line_start = '0;
    final_status = hrhp_pkg::ST_BUSY;
    final_length = '0;
    final_cut = 1'b0;
  endfunction

  function automatic void settle(input logic [2:0] status, input logic [15:0] len,
                                 input logic cut);
    step_phase = hrhp_pkg::PH_DONE;
    final_status = status;
    final_length = len;
    final_cut = cut;
  endfunction

  function automatic hrhp_pkg::out_word_t parse_byte(input hrhp_pkg::in_word_t w);
    logic [15:0] pos;
    logic [15:0] count;
    hrhp_pkg::out_word_t r;
    if (w.first_byte) restart_head();
    if (step_phase != hrhp_pkg::PH_DONE) begin
      pos = byte_count;
      count = pos + 16'd1;
      byte_count = count;
      case (step_phase)
        hrhp_pkg::PH_METHOD: begin
          if (match_pos < hrhp_pkg::METHOD_LAST) begin
            if (w.request_byte != GET_TEXT[23 - 8 * match_pos -: 8]) begin
              settle(hrhp_pkg::ST_METHOD, '0, 1'b0);
            end else begin
              match_pos = match_pos + 4'd1;
            end
          end else begin
            step_phase = hrhp_pkg::PH_URL;
            match_pos = '0;
          end
        end
        hrhp_pkg::PH_URL: begin
          if (w.request_byte == hrhp_pkg::CH_SPACE) begin
            step_phase = hrhp_pkg::PH_VERSION;
            match_pos = '0;
          end
        end
        hrhp_pkg::PH_VERSION: begin
          if (match_pos > hrhp_pkg::VERSION_LAST ||
              w.request_byte != VERSION_TEXT[79 - 8 * match_pos -: 8]) begin
            settle(hrhp_pkg::ST_VERSION, '0, 1'b0);
          end else if (match_pos == hrhp_pkg::VERSION_LAST) begin
            step_phase = hrhp_pkg::PH_LINE;
            match_pos = '0;
            line_start = count;
          end else begin
            match_pos = match_pos + 4'd1;
          end
        end
        hrhp_pkg::PH_LINE: begin
          line_start = pos;
          if (w.request_byte == hrhp_pkg::CH_CR) step_phase = hrhp_pkg::PH_LINE_CR;
          else if (w.request_byte == hrhp_pkg::CH_COLON) step_phase = hrhp_pkg::PH_LF;
          else step_phase = hrhp_pkg::PH_COLON;
        end
        hrhp_pkg::PH_LINE_CR: begin
          if (w.request_byte == hrhp_pkg::CH_LF) settle(hrhp_pkg::ST_OK, count, 1'b0);
          else if (w.request_byte == hrhp_pkg::CH_COLON) step_phase = hrhp_pkg::PH_LF;
          else step_phase = hrhp_pkg::PH_COLON;
        end
        hrhp_pkg::PH_COLON: begin
          if (w.request_byte == hrhp_pkg::CH_COLON) step_phase = hrhp_pkg::PH_LF;
        end
        hrhp_pkg::PH_LF: begin
          if (w.request_byte == hrhp_pkg::CH_LF) step_phase = hrhp_pkg::PH_LINE;
        end
        default: begin
          step_phase = hrhp_pkg::PH_DONE;
        end
      endcase
      if (step_phase != hrhp_pkg::PH_DONE &&
          (count == max_length_cfg || count == hrhp_pkg::COUNT_LIMIT)) begin
        if (step_phase <= hrhp_pkg::PH_VERSION) settle(hrhp_pkg::ST_LONG, '0, 1'b0);
        else if (line_start >= count) settle(hrhp_pkg::ST_OK, line_start, 1'b1);
        else settle(hrhp_pkg::ST_OK, line_start + 16'd1, 1'b1);
      end
    end
    r = '0;
    if (step_phase == hrhp_pkg::PH_DONE) begin
      r.status = final_status;
      r.head_length = final_length;
      r.newline_appended = final_cut;
    end
    return r;
  endfunction

  function automatic void push_word(input logic [7:0] b, input logic first);
    hrhp_pkg::in_word_t w;
    w.request_byte = b;
    w.first_byte = first;
    request_words.push_back(w);
    words_queued++;
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) request_bytes.push_back(s[i]);
  endfunction

  function automatic void add_crlf();
    request_bytes.push_back(hrhp_pkg::CH_CR);
    request_bytes.push_back(hrhp_pkg::CH_LF);
  endfunction

  function automatic void queue_bytes();
    foreach (request_bytes[i]) push_word(request_bytes[i], i == 0);
    request_bytes.delete();
    requests_queued++;
  endfunction

  task automatic queue_random_request();
    int pick;
    int n;
    int k;
    int version_at;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 8) begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom_range(255));
        push_word(b, i == 0 || $urandom_range(7) == 0);
      end
      requests_queued++;
    end else begin
      add_text("GET");
      b = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : hrhp_pkg::CH_SPACE;
      request_bytes.push_back(b);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom_range(33, 126));
        request_bytes.push_back(b);
      end
      request_bytes.push_back(hrhp_pkg::CH_SPACE);
      version_at = request_bytes.size();
      add_text("HTTP/1.0");
      add_crlf();
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(19) == 0) request_bytes.push_back(hrhp_pkg::CH_CR);
        k = $urandom_range(1, 5);
        for (int j = 0; j < k; j++) begin
          b = 8'($urandom_range(97, 122));
          request_bytes.push_back(b);
        end
        if ($urandom_range(9) != 0) request_bytes.push_back(hrhp_pkg::CH_COLON);
        request_bytes.push_back(hrhp_pkg::CH_SPACE);
        k = $urandom_range(0, 6);
        for (int j = 0; j < k; j++) begin
          b = 8'($urandom_range(32, 126));
          request_bytes.push_back(b);
        end
        add_crlf();
      end
      add_crlf();
      b = 8'($urandom_range(1, 255));
      if (pick < 20) begin
        k = $urandom_range(0, 2);
        request_bytes[k] = request_bytes[k] ^ b;
      end else if (pick < 32) begin
        k = version_at + $urandom_range(0, 9);
        request_bytes[k] = request_bytes[k] ^ b;
      end else if (pick < 44) begin
        k = $urandom_range(1, request_bytes.size());
        while (request_bytes.size() > k) void'(request_bytes.pop_back());
      end
      queue_bytes();
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(255));
          push_word(b, 1'b0);
        end
      end
    end
  endtask

  task automatic write_max_length(input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    max_length_cfg = cfg_data;
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained();
    while (words_accepted != words_queued || predicted_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_results.push_back(parse_byte(in_data));
        words_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (request_words.size() != 0 &&
            !((idle_mode == 0 && $urandom_range(99) < 31) ||
              (idle_mode == 1 && $urandom_range(99) < 46))) begin
          in_data <= request_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected status word %h with nothing predicted", $time, out_data);
          error_count++;
        end else begin
          want = predicted_results.pop_front();
          if (out_data.status != want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_data.status);
            error_count++;
          end
          if (out_data.head_length != want.head_length) begin
            $display("%0t: head_length mismatch, expected %0d, got %0d",
                     $time, want.head_length, out_data.head_length);
            error_count++;
          end
          if (out_data.newline_appended != want.newline_appended) begin
            $display("%0t: newline_appended mismatch, expected %0b, got %0b",
                     $time, want.newline_appended, out_data.newline_appended);
            error_count++;
          end
        end
      end
      out_ready <= !((idle_mode == 0 && $urandom_range(99) < 46) ||
                     (idle_mode == 1 && $urandom_range(99) < 31));
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int target;
    logic [15:0] setting;
    max_length_cfg = 16'd8192;
    restart_head();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    add_text("GET");
    request_bytes.push_back(8'h00);
    request_bytes.push_back(hrhp_pkg::CH_SPACE);
    add_text("HTTP/1.0");
    add_crlf();
    add_crlf();
    queue_bytes();
    push_word("P", 1'b1);
    push_word(8'hFF, 1'b0);
    requests_queued++;
    add_text("GET  X");
    queue_bytes();
    target = words_queued + 40;
    while (words_queued < target) queue_random_request();
    wait_drained();

    for (int p = 1; p <= 5; p++) begin
      idle_mode = (p < 2) ? 0 : (p < 4) ? 1 : 2;
      case (p)
        1: setting = 16'd16;
        2: setting = 16'd65535;
        3: setting = 16'd40;
        4: setting = 16'd17;
        default: setting = 16'd300;
      endcase
      write_max_length(setting);
      target = words_queued + 180;
      while (words_queued < target) queue_random_request();
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (predicted_results.size() != 0) begin
      $display("%0t: %0d predicted status words never arrived", $time, predicted_results.size());
      error_count++;
    end
    $display("Run covered %0d request words in %0d requests, %0d status words checked,",
             words_accepted, requests_queued, results_checked);
    $display("over %0d max_length settings and three pacing modes; %0d mismatches.",
             settings_used, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
